// File: sv/brle_pkg.sv
// brle_pkg: shared constants and types for the bounded ring list engine
// used by the channel interfaces, the entry ram, the sequencer and the top level
package brle_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_REM_FRONT = 3'd2,
    CMD_REM_BACK  = 3'd3,
    CMD_REM_AFTER = 3'd4,
    CMD_CLEAR     = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_EMPTY         = 3'd1,
    ST_FULL          = 3'd2,
    ST_NOKEY         = 3'd3,
    ST_NOTHING_AFTER = 3'd4
  } status_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage

// File: sv/brle_if.sv
// brle_cmd_if and brle_res_if: valid/ready channels for commands and results
// depends on brle_pkg for the data width
interface brle_cmd_if;
  import brle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [2:0]               command;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface brle_res_if;
  import brle_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic [4:0]               entry_count;
  logic signed [DATA_W-1:0] front_value;
  logic signed [DATA_W-1:0] back_value;

  modport source (output valid, output status, output entry_count, output front_value,
                  output back_value, input ready);
  modport sink   (input valid, input status, input entry_count, input front_value,
                  input back_value, output ready);
endinterface

// File: sv/brle_ram.sv
// brle_ram: entry store, one write port and one read port with registered data
// depends on brle_pkg for the request struct and sizes
module brle_ram (
  input  logic                         clk,
  input  brle_pkg::mem_req_t           req,
  output logic [brle_pkg::DATA_W-1:0]  rdata
);
  import brle_pkg::*;

  logic [DATA_W-1:0] mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// File: sv/brle_ctrl.sv
// brle_ctrl: command sequencer with front index, count, search and shift walk
// depends on brle_pkg, brle_cmd_if, brle_res_if; drives the entry ram request
module brle_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  brle_cmd_if.sink                     cmd_ch,
  brle_res_if.source                   res_ch,
  output brle_pkg::mem_req_t           mem_req,
  input  logic [brle_pkg::DATA_W-1:0]  rdata
);
  import brle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_SRCH, S_SHPRIME, S_SHIFT, S_RDF, S_RDB, S_DONE
  } state_t;

  state_t            state;
  logic [2:0]        cmd;
  logic [DATA_W-1:0] key;
  logic [IDX_W-1:0]  front;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  pos;
  status_t           st;
  logic [DATA_W-1:0] front_val;

  logic [CNT_W:0]    pos1;
  logic [CNT_W:0]    pos2;
  logic [CNT_W:0]    cnt_x;
  logic [CNT_W-1:0]  back_pos;
  logic [IDX_W-1:0]  front_dec;
  logic              full;
  logic              empty;
  logic              out_free;
  logic [CNT_W+4:0]  cnt_ext;

  // ring slot of a position counted from the front, position never above the depth
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] f,
                                               input logic [CNT_W:0] p);
    logic [CNT_W+1:0] s;
    s = (CNT_W+2)'(f) + (CNT_W+2)'(p);
    if (s >= (CNT_W+2)'(MAX_ENTRIES)) begin
      s = s - (CNT_W+2)'(MAX_ENTRIES);
    end
    return IDX_W'(s);
  endfunction

  assign pos1      = (CNT_W+1)'(pos) + (CNT_W+1)'(1);
  assign pos2      = (CNT_W+1)'(pos) + (CNT_W+1)'(2);
  assign cnt_x     = (CNT_W+1)'(count);
  assign back_pos  = (count == '0) ? '0 : count - 1'b1;
  assign front_dec = (front == '0) ? IDX_W'(MAX_ENTRIES - 1) : front - 1'b1;
  assign full      = (cnt_x >= (CNT_W+1)'(MAX_ENTRIES));
  assign empty     = (count == '0);
  assign out_free  = !res_ch.valid || res_ch.ready;
  assign cnt_ext   = (CNT_W+5)'(count);

  assign cmd_ch.ready = (state == S_IDLE);

  always_comb begin
    mem_req       = '0;
    mem_req.wdata = key;
    unique case (state)
      S_EXEC: begin
        if (cmd == CMD_INS_FRONT) begin
          mem_req.we    = !full;
          mem_req.waddr = front_dec;
        end else if (cmd == CMD_INS_BACK) begin
          mem_req.we    = !full;
          mem_req.waddr = slot_of(front, cnt_x);
        end
        mem_req.raddr = front;
      end
      S_SRCH:    mem_req.raddr = slot_of(front, pos1);
      S_SHPRIME: mem_req.raddr = slot_of(front, pos1);
      S_SHIFT: begin
        // move the entry one place toward the front while fetching the next
        mem_req.we    = 1'b1;
        mem_req.waddr = slot_of(front, (CNT_W+1)'(pos));
        mem_req.wdata = rdata;
        mem_req.raddr = slot_of(front, pos2);
      end
      S_RDF:  mem_req.raddr = front;
      S_RDB:  mem_req.raddr = slot_of(front, (CNT_W+1)'(back_pos));
      S_DONE: mem_req.raddr = slot_of(front, (CNT_W+1)'(back_pos));
      default: mem_req.raddr = front;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      front        <= '0;
      count        <= '0;
      res_ch.valid <= 1'b0;
    end else begin
      // in S_DONE the valid flag is written below
      if (res_ch.valid && res_ch.ready && state != S_DONE) begin
        res_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_ch.valid) begin
            cmd   <= cmd_ch.command;
            key   <= cmd_ch.value;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          st    <= ST_OK;
          state <= S_RDF;
          unique case (cmd)
            CMD_INS_FRONT: begin
              if (full) begin
                st <= ST_FULL;
              end else begin
                front <= front_dec;
                count <= count + 1'b1;
              end
            end
            CMD_INS_BACK: begin
              if (full) st <= ST_FULL;
              else count <= count + 1'b1;
            end
            CMD_REM_FRONT: begin
              if (empty) begin
                st <= ST_EMPTY;
              end else begin
                front <= slot_of(front, (CNT_W+1)'(1));
                count <= count - 1'b1;
              end
            end
            CMD_REM_BACK: begin
              if (empty) st <= ST_EMPTY;
              else count <= count - 1'b1;
            end
            CMD_REM_AFTER: begin
              if (empty) begin
                st <= ST_EMPTY;
              end else begin
                pos   <= '0;
                state <= S_SRCH;
              end
            end
            CMD_CLEAR: begin
              if (empty) st <= ST_EMPTY;
              else count <= '0;
            end
            default: ;
          endcase
        end
        S_SRCH: begin
          // rdata holds the entry at pos
          if (rdata == key) begin
            if (pos1 >= cnt_x) begin
              st    <= ST_NOTHING_AFTER;
              state <= S_RDF;
            end else if (pos2 >= cnt_x) begin
              count <= count - 1'b1;
              state <= S_RDF;
            end else begin
              pos   <= CNT_W'(pos1);
              state <= S_SHPRIME;
            end
          end else if (pos1 >= cnt_x) begin
            st    <= ST_NOKEY;
            state <= S_RDF;
          end else begin
            pos <= CNT_W'(pos1);
          end
        end
        S_SHPRIME: state <= S_SHIFT;
        S_SHIFT: begin
          pos <= CNT_W'(pos1);
          if (pos2 >= cnt_x) begin
            count <= count - 1'b1;
            state <= S_RDF;
          end
        end
        S_RDF: state <= S_RDB;
        S_RDB: begin
          front_val <= rdata;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            res_ch.valid       <= 1'b1;
            res_ch.status      <= st;
            res_ch.entry_count <= cnt_ext[4:0];
            res_ch.front_value <= empty ? '0 : front_val;
            res_ch.back_value  <= empty ? '0 : rdata;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/bounded_ring_list_engine.sv
// bounded_ring_list_engine: top level, sequencer plus entry ram
// depends on brle_pkg, brle_if, brle_ram, brle_ctrl
//
// Ordered ring of up to MAX_ENTRIES signed 32-bit values held in a single-port-read
// ram and addressed from a front index. One command is taken at a time: ready is
// high only while the sequencer is idle, and a result waiting in the output
// register does not block the next command. Insert, remove front or back, clear
// and unused codes pass through the execute, read front, read back and done states
// before the result is registered, and no new command is taken until the
// sequencer is back in idle; every command ends with two ram reads that fetch the
// front and back values. Remove after key adds a search step per entry searched
// and, when entries have to move to close the gap, a priming step plus one shift
// step per entry moved. A result that is not taken holds the sequencer in its
// last state. The store has no reset; unwritten slots may be read, but their
// contents never reach a result.
module bounded_ring_list_engine (
  input logic        clk,
  input logic        rst,
  brle_cmd_if.sink   cmd_ch,
  brle_res_if.source res_ch
);
  import brle_pkg::*;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] rdata;

  brle_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cmd_ch  (cmd_ch),
    .res_ch  (res_ch),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  brle_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

endmodule

// File: sv/brle_checker.sv
// brle_checker: port-level assertions for the bounded ring list engine
// depends on brle_pkg; bound to bounded_ring_list_engine below
module brle_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         cmd_valid,
  input logic                         cmd_ready,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [2:0]                   status,
  input logic [4:0]                   entry_count,
  input logic [brle_pkg::DATA_W-1:0]  front_value,
  input logic [brle_pkg::DATA_W-1:0]  back_value
);
  import brle_pkg::*;

  // a stalled result keeps its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(entry_count)
      && $stable(front_value) && $stable(back_value))
    else $error("result changed while stalled");

  // one command at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while busy");

  // an empty status leaves an empty ring
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == ST_EMPTY) |-> entry_count == '0 && front_value == '0
      && back_value == '0)
    else $error("empty status with entries held");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind bounded_ring_list_engine brle_checker u_brle_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd_ch.valid),
  .cmd_ready   (cmd_ch.ready),
  .res_valid   (res_ch.valid),
  .res_ready   (res_ch.ready),
  .status      (res_ch.status),
  .entry_count (res_ch.entry_count),
  .front_value (res_ch.front_value),
  .back_value  (res_ch.back_value)
);
